// ===== rtl/core/gle_pkg.sv =====
// Shared constants and types of the GIF LZW encoder.
// No dependencies; imported by every module of the encoder.
`default_nettype none
package gle_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int ROOT_BITS     = 8;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int WIDTH_W       = 4;
    localparam int IDX_W         = MAX_CODE_BITS + ROOT_BITS;
    localparam int DICT_DEPTH    = 1 << IDX_W;
    localparam int KEY_DEPTH     = 1 << MAX_CODE_BITS;
    localparam int JOB_DEPTH     = 5;
    localparam int JOB_CNT_W     = 3;

    localparam logic [CODE_W-1:0]  CLEAR_CODE = CODE_W'(1 << ROOT_BITS);
    localparam logic [CODE_W-1:0]  END_CODE   = CODE_W'((1 << ROOT_BITS) + 1);
    localparam logic [CODE_W-1:0]  FIRST_FREE = CODE_W'((1 << ROOT_BITS) + 2);
    localparam logic [CODE_W-1:0]  CLEAR_AT   = CODE_W'((1 << MAX_CODE_BITS) - 1);
    localparam logic [WIDTH_W-1:0] ROOT_WIDTH = WIDTH_W'(ROOT_BITS + 1);
    localparam logic [WIDTH_W-1:0] MAX_WIDTH  = WIDTH_W'(MAX_CODE_BITS);

    // One code on its way to the bit packer
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [WIDTH_W-1:0] width;
        logic               item_end;
        logic               flush;
    } code_item_t;

    // Dictionary and back-pointer write
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
    } dict_wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/gle_dict.sv =====
// Dictionary memory (key to code) and back-pointer memory (code to key).
// Depends on gle_pkg; both memories have registered reads with enables.
`default_nettype none
module gle_dict
    import gle_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              dict_rd_en,
    input  wire logic [IDX_W-1:0]  dict_rd_idx,
    output logic      [CODE_W-1:0] dict_rd_code,
    input  wire logic              key_rd_en,
    input  wire logic [CODE_W-1:0] key_rd_code,
    output logic      [IDX_W-1:0]  key_rd_idx,
    input  wire dict_wr_t          wr
);

    logic [CODE_W-1:0] dict_mem [DICT_DEPTH];
    logic [IDX_W-1:0]  key_mem  [KEY_DEPTH];
    logic [CODE_W-1:0] dict_q_reg;
    logic [IDX_W-1:0]  key_q_reg;

    // Write both directions of a new entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            dict_mem[wr.idx] <= wr.code;
            key_mem[wr.code] <= wr.idx;
        end
    end

    // Read ports, held while not enabled
    always_ff @(posedge clk)
    begin
        if (dict_rd_en)
        begin
            dict_q_reg <= dict_mem[dict_rd_idx];
        end
        if (key_rd_en)
        begin
            key_q_reg <= key_mem[key_rd_code];
        end
    end

    assign dict_rd_code = dict_q_reg;
    assign key_rd_idx   = key_q_reg;

endmodule
`default_nettype wire

// ===== rtl/core/gle_packer.sv =====
// Code queue, LSB-first bit packer and output byte register.
// Depends on gle_pkg; takes up to JOB_DEPTH codes per load.
`default_nettype none
module gle_packer
    import gle_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 job_load,
    input  wire code_item_t           job_in [JOB_DEPTH],
    input  wire logic [JOB_CNT_W-1:0] job_in_cnt,
    output logic                      job_free,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_byte,
    output logic                      last_of_item,
    output logic                      end_of_stream
);

    localparam int ACC_W = 27;

    code_item_t           job_reg [JOB_DEPTH];
    logic [JOB_CNT_W-1:0] job_cnt_reg, job_cnt_next;
    logic [ACC_W-1:0]     acc_reg, acc_next, acc_s;
    logic [4:0]           cnt_reg, cnt_next, cnt_s;
    logic [2:0]           lmark_reg, lmark_next, lmark_s;
    logic [2:0]           emark_reg, emark_next, emark_s;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg, out_eos_reg;
    logic                 out_free, emit, absorb;
    logic [CODE_W-1:0]    mask;
    logic [5:0]           cnt_t;
    logic [1:0]           nb;

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = (cnt_reg >= 5'd8) && out_free;
    assign job_free = (job_cnt_reg == '0) || ((job_cnt_reg == JOB_CNT_W'(1)) && absorb);

    // Shift out one byte, then absorb the head code
    always_comb
    begin
        acc_s   = emit ? (acc_reg >> 8) : acc_reg;
        cnt_s   = emit ? (cnt_reg - 5'd8) : cnt_reg;
        lmark_s = emit ? {1'b0, lmark_reg[2:1]} : lmark_reg;
        emark_s = emit ? {1'b0, emark_reg[2:1]} : emark_reg;
        absorb  = (job_cnt_reg != '0) &&
                  (job_reg[0].flush ? (cnt_s <= 5'd12) : (cnt_s <= 5'd15));
        mask    = CODE_W'((13'd1 << job_reg[0].width) - 13'd1);
        cnt_t   = {1'b0, cnt_s} + {2'b0, job_reg[0].width};
        if (job_reg[0].flush)
        begin
            cnt_t = (cnt_t + 6'd7) & 6'b111000;
        end
        nb         = cnt_t[4:3];
        acc_next   = acc_s;
        cnt_next   = cnt_s;
        lmark_next = lmark_s;
        emark_next = emark_s;
        if (absorb)
        begin
            acc_next = acc_s | (ACC_W'(job_reg[0].code & mask) << cnt_s);
            cnt_next = cnt_t[4:0];
            if (job_reg[0].item_end && (nb != 2'd0))
            begin
                lmark_next[nb - 2'd1] = 1'b1;
            end
            if (job_reg[0].flush && (nb != 2'd0))
            begin
                emark_next[nb - 2'd1] = 1'b1;
            end
        end
    end

    // Queue count: load replaces, pop drops the head
    always_comb
    begin
        job_cnt_next = job_cnt_reg;
        if (job_load)
        begin
            job_cnt_next = job_in_cnt;
        end
        else if (absorb)
        begin
            job_cnt_next = job_cnt_reg - JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_cnt_reg   <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            lmark_reg     <= '0;
            emark_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_cnt_reg <= job_cnt_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            lmark_reg   <= lmark_next;
            emark_reg   <= emark_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Queue payload and output byte payload
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job_in;
        end
        else if (absorb)
        begin
            for (int i = 0; i < JOB_DEPTH - 1; i++)
            begin
                job_reg[i] <= job_reg[i + 1];
            end
        end
        if (emit)
        begin
            out_byte_reg <= acc_reg[7:0];
            out_last_reg <= lmark_reg[0];
            out_eos_reg  <= emark_reg[0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last_of_item  = out_last_reg;
    assign end_of_stream = out_eos_reg;

endmodule
`default_nettype wire

// ===== rtl/core/gif_lzw_encoder.sv =====
// GIF LZW encoder: a pixel passes a dictionary read, then a back-pointer read, with
// the new prefix fed to the next lookup; a new pixel waits until the last one leaves
// the dictionary read. Bytes leave at most one per cycle, while the receiver is ready.
// Reset is asynchronous, active low. Memories are not cleared: an entry is trusted
// only if its code lies in [258, next code) and its back pointer names the same key.
// Depends on gle_pkg, gle_dict and gle_packer.
`default_nettype none
module gif_lzw_encoder
    import gle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] pixel_index,
    input  wire logic       last_pixel,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last_of_item,
    output logic            end_of_stream
);

    logic                 s1_valid_reg, s2_valid_reg;
    logic [ROOT_BITS-1:0] s1_pix_reg, s2_pix_reg;
    logic                 s1_last_reg, s2_last_reg;
    logic [IDX_W-1:0]     s1_idx_reg, s2_idx_reg;
    logic                 s1_fwd_reg;
    logic [CODE_W-1:0]    s1_fwd_code_reg, s2_code_reg, s1_code;

    logic [CODE_W-1:0]    prefix_reg, prefix_next;
    logic                 present_reg, present_next;
    logic [CODE_W-1:0]    nf_reg, nf_next, nf1;
    logic [WIDTH_W-1:0]   cb_reg, cb_next, cb1;
    logic                 started_reg, started_next;

    logic                 accept, s1_adv, s2_fire, job_free, hit;
    logic [CODE_W-1:0]    dict_q;
    logic [IDX_W-1:0]     key_q, rd_idx;
    dict_wr_t             wr;
    code_item_t           job [JOB_DEPTH];
    logic [JOB_CNT_W-1:0] job_cnt;

    // Pipeline control
    assign s2_fire  = s2_valid_reg && job_free;
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign in_ready = !s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign accept   = in_valid && in_ready;
    assign rd_idx   = {prefix_next, pixel_index[ROOT_BITS-1:0]};
    assign s1_code  = s1_fwd_reg ? s1_fwd_code_reg : dict_q;

    // Decide hit or miss, update state, list the codes to send
    always_comb
    begin
        prefix_next  = prefix_reg;
        present_next = present_reg;
        nf_next      = nf_reg;
        cb_next      = cb_reg;
        started_next = started_reg;
        wr           = '0;
        job_cnt      = '0;
        nf1          = nf_reg + CODE_W'(1);
        cb1          = cb_reg;
        for (int i = 0; i < JOB_DEPTH; i++)
        begin
            job[i] = '0;
        end
        hit = 1'b0;
        if (present_reg && (s2_code_reg >= FIRST_FREE) && (s2_code_reg < nf_reg)
            && (key_q == s2_idx_reg))
        begin
            hit = 1'b1;
        end
        if (s2_fire)
        begin
            if (!started_reg)
            begin
                job[job_cnt] = '{code: CLEAR_CODE, width: cb_reg, item_end: 1'b0,
                                 flush: 1'b0};
                job_cnt      = job_cnt + JOB_CNT_W'(1);
                started_next = 1'b1;
            end
            if (!present_reg)
            begin
                prefix_next  = CODE_W'(s2_pix_reg);
                present_next = 1'b1;
            end
            else if (hit)
            begin
                prefix_next = s2_code_reg;
            end
            else
            begin
                wr           = '{en: 1'b1, idx: s2_idx_reg, code: nf_reg};
                job[job_cnt] = '{code: prefix_reg, width: cb_reg, item_end: 1'b0,
                                 flush: 1'b0};
                job_cnt      = job_cnt + JOB_CNT_W'(1);
                if (({1'b0, nf1} == ((13'd1 << cb_reg) + 13'd1)) && (cb_reg < MAX_WIDTH))
                begin
                    cb1 = cb_reg + WIDTH_W'(1);
                end
                if (nf1 >= CLEAR_AT)
                begin
                    job[job_cnt] = '{code: CLEAR_CODE, width: cb1, item_end: 1'b0,
                                     flush: 1'b0};
                    job_cnt      = job_cnt + JOB_CNT_W'(1);
                    nf_next      = FIRST_FREE;
                    cb_next      = ROOT_WIDTH;
                end
                else
                begin
                    nf_next = nf1;
                    cb_next = cb1;
                end
                prefix_next = CODE_W'(s2_pix_reg);
            end
            if (s2_last_reg)
            begin
                job[job_cnt] = '{code: prefix_next, width: cb_next, item_end: 1'b0,
                                 flush: 1'b0};
                job_cnt      = job_cnt + JOB_CNT_W'(1);
                job[job_cnt] = '{code: END_CODE, width: cb_next, item_end: 1'b0,
                                 flush: 1'b1};
                job_cnt      = job_cnt + JOB_CNT_W'(1);
                prefix_next  = '0;
                present_next = 1'b0;
                nf_next      = FIRST_FREE;
                cb_next      = ROOT_WIDTH;
                started_next = 1'b0;
            end
            if (job_cnt != '0)
            begin
                job[job_cnt - JOB_CNT_W'(1)].item_end = 1'b1;
            end
        end
    end

    // Control and encoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            prefix_reg   <= '0;
            present_reg  <= 1'b0;
            nf_reg       <= FIRST_FREE;
            cb_reg       <= ROOT_WIDTH;
            started_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !s1_adv);
            s2_valid_reg <= s1_adv || (s2_valid_reg && !s2_fire);
            prefix_reg   <= prefix_next;
            present_reg  <= present_next;
            nf_reg       <= nf_next;
            cb_reg       <= cb_next;
            started_reg  <= started_next;
        end
    end

    // Stage payloads; forward a same-cycle write to the lookup
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= pixel_index[ROOT_BITS-1:0];
            s1_last_reg     <= last_pixel;
            s1_idx_reg      <= rd_idx;
            s1_fwd_reg      <= wr.en && (wr.idx == rd_idx);
            s1_fwd_code_reg <= wr.code;
        end
        if (s1_adv)
        begin
            s2_pix_reg  <= s1_pix_reg;
            s2_last_reg <= s1_last_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_code_reg <= s1_code;
        end
    end

    gle_dict u_dict (
        .clk          (clk),
        .dict_rd_en   (accept),
        .dict_rd_idx  (rd_idx),
        .dict_rd_code (dict_q),
        .key_rd_en    (s1_adv),
        .key_rd_code  (s1_code),
        .key_rd_idx   (key_q),
        .wr           (wr)
    );

    gle_packer u_packer (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_load      (s2_fire),
        .job_in        (job),
        .job_in_cnt    (job_cnt),
        .job_free      (job_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_item  (last_of_item),
        .end_of_stream (end_of_stream)
    );

endmodule
`default_nettype wire

// ===== verif/gle_stream_checker.sv =====
// Watches both channels of the GIF LZW encoder, predicts the code byte stream
// and compares each delivered byte. Depends on gle_pkg.
`default_nettype none
module gle_stream_checker
    import gle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] pixel_index,
    input  wire logic       last_pixel,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       last_of_item,
    input  wire logic       end_of_stream,
    output int              errors,
    output int              bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       item_end;
        logic       stream_end;
    } code_byte_t;

    // Encoder state mirrored here
    logic [CODE_W-1:0]  dict_code [bit [IDX_W-1:0]];
    logic [CODE_W-1:0]  prefix;
    logic               have_prefix;
    int                 next_code;
    int                 code_width;
    logic [6:0]         spare_bits;
    int                 spare_cnt;
    logic               started;

    code_byte_t         byte_fifo[$];
    logic [7:0]         item_bytes[$];

    function automatic void restart_stream();
        dict_code.delete();
        prefix      = '0;
        have_prefix = 1'b0;
        next_code   = int'(FIRST_FREE);
        code_width  = int'(ROOT_WIDTH);
        spare_bits  = '0;
        spare_cnt   = 0;
        started     = 1'b0;
    endfunction

    // Append one code LSB-first; collect every completed byte
    function automatic void pack_code(logic [CODE_W-1:0] code, int width);
        logic [31:0] acc;
        int          cnt;
        acc = 32'(spare_bits) | ((32'(code) & ((32'd1 << width) - 1)) << spare_cnt);
        cnt = spare_cnt + width;
        while (cnt >= 8)
        begin
            item_bytes.push_back(acc[7:0]);
            acc = acc >> 8;
            cnt -= 8;
        end
        spare_bits = acc[6:0];
        spare_cnt  = cnt;
    endfunction

    function automatic void encode_pixel(logic [7:0] pix, logic fin);
        logic [ROOT_BITS-1:0] sym;
        logic [IDX_W-1:0]     key;
        code_byte_t           cb;
        sym = pix[ROOT_BITS-1:0];
        item_bytes.delete();
        if (!started)
        begin
            pack_code(CLEAR_CODE, code_width);
            started = 1'b1;
        end
        if (!have_prefix)
        begin
            prefix      = CODE_W'(sym);
            have_prefix = 1'b1;
        end
        else
        begin
            key = {prefix, sym};
            if (dict_code.exists(key))
                prefix = dict_code[key];
            else
            begin
                if (next_code < KEY_DEPTH)
                    dict_code[key] = CODE_W'(next_code);
                next_code++;
                pack_code(prefix, code_width);
                if (next_code == (1 << code_width) + 1 && code_width < MAX_CODE_BITS)
                    code_width++;
                // Dictionary full: send clear and restart the table
                if (next_code >= int'(CLEAR_AT))
                begin
                    pack_code(CLEAR_CODE, code_width);
                    dict_code.delete();
                    next_code  = int'(FIRST_FREE);
                    code_width = int'(ROOT_WIDTH);
                end
                prefix = CODE_W'(sym);
            end
        end
        if (fin)
        begin
            pack_code(prefix, code_width);
            pack_code(END_CODE, code_width);
            if (spare_cnt > 0)
                item_bytes.push_back({1'b0, spare_bits});
        end
        foreach (item_bytes[i])
        begin
            cb.data       = item_bytes[i];
            cb.item_end   = (i == item_bytes.size() - 1);
            cb.stream_end = fin && (i == item_bytes.size() - 1);
            byte_fifo.push_back(cb);
        end
        if (fin)
            restart_stream();
    endfunction

    initial
    begin
        errors = 0;
        restart_stream();
    end

    assign bytes_owed = byte_fifo.size();

    // Predict on each input transaction, compare on each output transaction
    always @(posedge clk)
    begin
        code_byte_t exp_b;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                encode_pixel(pixel_index, last_pixel);
            if (out_valid && out_ready)
            begin
                if (byte_fifo.size() == 0)
                begin
                    $error("unexpected byte %0h", out_byte);
                    errors++;
                end
                else
                begin
                    exp_b = byte_fifo.pop_front();
                    if (out_byte !== exp_b.data)
                    begin
                        $error("out_byte expected %0h actual %0h", exp_b.data, out_byte);
                        errors++;
                    end
                    if (last_of_item !== exp_b.item_end)
                    begin
                        $error("last_of_item expected %0b actual %0b",
                               exp_b.item_end, last_of_item);
                        errors++;
                    end
                    if (end_of_stream !== exp_b.stream_end)
                    begin
                        $error("end_of_stream expected %0b actual %0b",
                               exp_b.stream_end, end_of_stream);
                        errors++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb_gif_lzw_encoder.sv =====
// Top of the GIF LZW encoder testbench: clock, reset, pixel stimulus and verdict.
// Depends on gle_pkg, gif_lzw_encoder and gle_stream_checker.
`default_nettype none
module tb_gif_lzw_encoder;
    import gle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] pixel_index;
    logic       last_pixel;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_stream;

    int         errors;
    int         bytes_owed;
    int         cycles;
    int         send_idle_pct;
    int         recv_stall_pct;
    logic       hold_off;
    logic       pressure_go;

    gif_lzw_encoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_index  (pixel_index),
        .last_pixel   (last_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_stream(end_of_stream)
    );

    gle_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_index  (pixel_index),
        .last_pixel   (last_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_stream(end_of_stream),
        .errors       (errors),
        .bytes_owed   (bytes_owed)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off while the sender keeps going
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        hold_off = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one pixel and hold it until the transaction completes
    task automatic send_pixel(input logic [7:0] pix, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_index <= pix;
        last_pixel  <= fin;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Image over a few symbols (random bytes if symbols is 0) so the dictionary gets hits and long prefixes
    task automatic send_image(input int len, input int symbols);
        logic [7:0] alphabet[4];
        logic [7:0] pix;
        foreach (alphabet[i])
            alphabet[i] = 8'($urandom);
        for (int i = 0; i < len; i++)
        begin
            if (symbols == 0)
                pix = 8'($urandom);
            else
                pix = alphabet[$urandom_range(symbols - 1)];
            send_pixel(pix, i == len - 1);
        end
    endtask

    initial
    begin
        int sent;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pixel_index    = '0;
        last_pixel     = 1'b0;
        out_ready      = 1'b0;
        pressure_go    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-pixel image, extremes, repeats, stream restart
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b1);
        for (int i = 0; i < 10; i++)
            send_pixel(8'h80, i == 9);

        // Long image: code width grows past its starting value
        send_image(300, 0);

        // Random images under each idling mix
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            sent = 0;
            while (sent < 30)
            begin
                int len;
                len = $urandom_range(1, 40);
                if (ph == 0)
                    pressure_go = 1'b1;
                send_image(len, $urandom_range(0, 4));
                sent += len;
            end
        end
        in_valid <= 1'b0;
        last_pixel <= 1'b0;
        recv_stall_pct = 0;

        while (bytes_owed != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0 && bytes_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/gle_pkg.sv
rtl/core/gle_dict.sv
rtl/core/gle_packer.sv
rtl/core/gif_lzw_encoder.sv
verif/gle_stream_checker.sv
verif/tb_gif_lzw_encoder.sv
